### design/jhdp_pkg.sv
package jhdp_pkg;

    typedef enum logic [3:0] {
        PH_SYNC    = 4'd0,
        PH_MARKER  = 4'd1,
        PH_FLEN_HI = 4'd2,
        PH_FLEN_LO = 4'd3,
        PH_PREC    = 4'd4,
        PH_H_HI    = 4'd5,
        PH_H_LO    = 4'd6,
        PH_W_HI    = 4'd7,
        PH_W_LO    = 4'd8,
        PH_SLEN_HI = 4'd9,
        PH_SLEN_LO = 4'd10,
        PH_SKIP    = 4'd11
    } phase_t;

    typedef enum logic [1:0] {
        CAUSE_SOS  = 2'd0,
        CAUSE_SYNC = 2'd1,
        CAUSE_EOD  = 2'd2,
        CAUSE_PROG = 2'd3
    } cause_t;

    localparam logic [7:0] SYNC_BYTE = 8'hFF;
    localparam logic [7:0] MK_SOF0   = 8'hC0;
    localparam logic [7:0] MK_SOF2   = 8'hC2;
    localparam logic [7:0] MK_SOI    = 8'hD8;
    localparam logic [7:0] MK_SOS    = 8'hDA;
    localparam logic [7:0] MK_DRI    = 8'hDD;

    // bytes of a frame header up to and including the width field
    localparam logic [15:0] FRAME_HDR_LEN = 16'd7;
    // the length field counts itself
    localparam logic [15:0] LEN_FIELD_LEN = 16'd2;
    localparam logic [15:0] DRI_BODY_LEN  = 16'd4;

    typedef struct packed {
        logic        found;
        logic [15:0] width;
        logic [15:0] height;
        cause_t      cause;
    } result_t;

endpackage

### design/jpeg_header_dimension_parser_unit.sv
// Channel | Direction | Ports
// s_      | in        | s_valid, s_ready, s_data_byte[7:0], s_last_byte
// m_      | out       | m_valid, m_ready, m_found_frame, m_image_width[15:0],
//         |           | m_image_height[15:0], m_end_cause[1:0]
//
// One byte per cycle while no waiting result stalls the pipe; the result for the byte that
// ends the parse passes the input register, then the result register.
// The parser state update is a single step per byte between those two registers.
// Reset is synchronous on aresetn low and returns the parser to expecting a sync byte.
// A stalled result register holds the pipe; the input register still takes one word if it is empty.
module jpeg_header_dimension_parser_unit
    import jhdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found_frame,
    output logic [15:0] m_image_width,
    output logic [15:0] m_image_height,
    output logic [1:0]  m_end_cause
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_free;
    logic       step_en;
    logic       res_valid;
    result_t    res;

    // advance a byte only when its result, if any, has somewhere to go
    assign step_en = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    jhdp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (step_en),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    jhdp_out_reg u_out (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (res_valid),
        .res            (res),
        .m_ready        (m_ready),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_found_frame  (m_found_frame),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height),
        .m_end_cause    (m_end_cause)
    );

endmodule

### design/jhdp_parser.sv
module jhdp_parser
    import jhdp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       res_valid,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [15:0] skip_reg, skip_next;
    logic [15:0] seglen_reg, seglen_next;
    logic [15:0] height_reg, height_next;
    logic [15:0] width_reg, width_next;
    logic        found_reg, found_next;
    logic        finished_reg, finished_next;

    logic        ended;
    cause_t      cause;
    logic [15:0] len_full;

    assign len_full = {seglen_reg[15:8], data_byte};

    always_comb begin
        phase_next    = phase_reg;
        skip_next     = skip_reg;
        seglen_next   = seglen_reg;
        height_next   = height_reg;
        width_next    = width_reg;
        found_next    = found_reg;
        finished_next = finished_reg;
        ended         = 1'b0;
        cause         = CAUSE_EOD;

        if (!finished_reg) begin
            case (phase_reg)
                PH_MARKER: begin
                    if (data_byte == MK_SOS) begin
                        ended = 1'b1;
                        cause = CAUSE_SOS;
                    end else if (data_byte == MK_SOF2) begin
                        ended = 1'b1;
                        cause = CAUSE_PROG;
                    end else if (data_byte == MK_SOI) begin
                        phase_next = PH_SYNC;
                    end else if (data_byte == MK_DRI) begin
                        skip_next  = DRI_BODY_LEN;
                        phase_next = PH_SKIP;
                    end else if (data_byte == MK_SOF0) begin
                        phase_next = PH_FLEN_HI;
                    end else begin
                        phase_next = PH_SLEN_HI;
                    end
                end
                PH_FLEN_HI: begin
                    seglen_next = {data_byte, 8'h00};
                    phase_next  = PH_FLEN_LO;
                end
                PH_FLEN_LO: begin
                    seglen_next = len_full;
                    phase_next  = PH_PREC;
                end
                PH_PREC: begin
                    phase_next = PH_H_HI;
                end
                PH_H_HI: begin
                    height_next = {data_byte, height_reg[7:0]};
                    phase_next  = PH_H_LO;
                end
                PH_H_LO: begin
                    height_next = {height_reg[15:8], data_byte};
                    phase_next  = PH_W_HI;
                end
                PH_W_HI: begin
                    width_next = {data_byte, width_reg[7:0]};
                    phase_next = PH_W_LO;
                end
                PH_W_LO: begin
                    width_next = {width_reg[15:8], data_byte};
                    found_next = 1'b1;
                    if (seglen_reg > FRAME_HDR_LEN) begin
                        skip_next  = seglen_reg - FRAME_HDR_LEN;
                        phase_next = PH_SKIP;
                    end else begin
                        skip_next  = '0;
                        phase_next = PH_SYNC;
                    end
                end
                PH_SLEN_HI: begin
                    seglen_next = {data_byte, 8'h00};
                    phase_next  = PH_SLEN_LO;
                end
                PH_SLEN_LO: begin
                    seglen_next = len_full;
                    if (len_full > LEN_FIELD_LEN) begin
                        skip_next  = len_full - LEN_FIELD_LEN;
                        phase_next = PH_SKIP;
                    end else begin
                        skip_next  = '0;
                        phase_next = PH_SYNC;
                    end
                end
                PH_SKIP: begin
                    skip_next = skip_reg - 16'd1;
                    if (skip_reg == 16'd1) begin
                        phase_next = PH_SYNC;
                    end
                end
                default: begin
                    if (data_byte != SYNC_BYTE) begin
                        ended = 1'b1;
                        cause = CAUSE_SYNC;
                    end else begin
                        phase_next = PH_MARKER;
                    end
                end
            endcase

            // end of data only when nothing else ended the parse
            if (!ended && last_byte) begin
                ended = 1'b1;
                cause = CAUSE_EOD;
            end
            if (ended && !last_byte) begin
                finished_next = 1'b1;
            end
        end
    end

    assign res_valid  = step_en && ended;
    assign res.found  = found_next;
    assign res.width  = found_next ? width_next : 16'd0;
    assign res.height = found_next ? height_next : 16'd0;
    assign res.cause  = cause;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SYNC;
            skip_reg     <= '0;
            seglen_reg   <= '0;
            height_reg   <= '0;
            width_reg    <= '0;
            found_reg    <= 1'b0;
            finished_reg <= 1'b0;
        end else if (step_en) begin
            if (last_byte) begin
                // re-arm on the final byte of the file
                phase_reg    <= PH_SYNC;
                skip_reg     <= '0;
                seglen_reg   <= '0;
                height_reg   <= '0;
                width_reg    <= '0;
                found_reg    <= 1'b0;
                finished_reg <= 1'b0;
            end else begin
                phase_reg    <= phase_next;
                skip_reg     <= skip_next;
                seglen_reg   <= seglen_next;
                height_reg   <= height_next;
                width_reg    <= width_next;
                found_reg    <= found_next;
                finished_reg <= finished_next;
            end
        end
    end

    a_skip_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_SKIP |-> skip_reg != 16'd0)
        else $error("skip phase with zero count");

    a_silent_after_end: assert property (@(posedge aclk) disable iff (!aresetn)
        finished_reg |-> !res_valid)
        else $error("result after parse end");

    a_end_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !last_byte |=> finished_reg)
        else $error("parse end not held");

    a_last_rearms: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && last_byte |=> !finished_reg && !found_reg && phase_reg == PH_SYNC)
        else $error("final byte did not re-arm");

endmodule

### design/jhdp_out_reg.sv
module jhdp_out_reg
    import jhdp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  result_t     res,
    input  logic        m_ready,
    output logic        out_free,
    output logic        m_valid,
    output logic        m_found_frame,
    output logic [15:0] m_image_width,
    output logic [15:0] m_image_height,
    output logic [1:0]  m_end_cause
);

    logic    valid_reg;
    result_t res_reg;

    // slot frees up in the same cycle the waiting word is taken
    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && load) begin
            res_reg <= res;
        end
    end

    assign m_valid        = valid_reg;
    assign m_found_frame  = res_reg.found;
    assign m_image_width  = res_reg.width;
    assign m_image_height = res_reg.height;
    assign m_end_cause    = res_reg.cause;

    a_no_size_without_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !res_reg.found |-> res_reg.width == 16'd0 && res_reg.height == 16'd0)
        else $error("size given without frame header");

endmodule

### sim/jpeg_header_dimension_parser_unit_tb.sv
`timescale 1ns / 100ps

module jpeg_header_dimension_parser_unit_tb;
    import jhdp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_BYTES = 1200;
    localparam int CALM_BYTES   = 300;

    // Walks the marker segments of each file as the block should and keeps
    // the frame sizes it expects to see reported, oldest first.
    class frame_size_scoreboard;
        phase_t      phase;
        logic [15:0] skip_left;
        logic [15:0] seg_len;
        logic [15:0] height;
        logic [15:0] width;
        logic        found;
        logic        finished;
        result_t     expected_sizes[$];
        int          errors;

        function new();
            errors = 0;
            rearm();
        endfunction

        function void rearm();
            phase     = PH_SYNC;
            skip_left = '0;
            seg_len   = '0;
            height    = '0;
            width     = '0;
            found     = 1'b0;
            finished  = 1'b0;
        endfunction

        function void begin_skip(logic [15:0] n);
            skip_left = n;
            phase     = (n == 0) ? PH_SYNC : PH_SKIP;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        function int pending();
            return expected_sizes.size();
        endfunction

        task note_byte(logic [7:0] b, logic last);
            cause_t  why;
            logic    ends;
            result_t r;
            ends = 1'b0;
            why  = CAUSE_SOS;
            // after an ending, ignore everything up to the file's last word
            if (finished) begin
                if (last)
                    rearm();
                return;
            end
            case (phase)
                PH_MARKER: begin
                    if (b == MK_SOS) begin
                        ends = 1'b1;
                        why  = CAUSE_SOS;
                    end else if (b == MK_SOF2) begin
                        ends = 1'b1;
                        why  = CAUSE_PROG;
                    end else if (b == MK_SOI) begin
                        phase = PH_SYNC;
                    end else if (b == MK_DRI) begin
                        begin_skip(DRI_BODY_LEN);
                    end else if (b == MK_SOF0) begin
                        phase = PH_FLEN_HI;
                    end else begin
                        phase = PH_SLEN_HI;
                    end
                end
                PH_FLEN_HI: begin
                    seg_len = {b, 8'h00};
                    phase   = PH_FLEN_LO;
                end
                PH_FLEN_LO: begin
                    seg_len[7:0] = b;
                    phase        = PH_PREC;
                end
                PH_PREC: phase = PH_H_HI;
                PH_H_HI: begin
                    height[15:8] = b;
                    phase        = PH_H_LO;
                end
                PH_H_LO: begin
                    height[7:0] = b;
                    phase       = PH_W_HI;
                end
                PH_W_HI: begin
                    width[15:8] = b;
                    phase       = PH_W_LO;
                end
                PH_W_LO: begin
                    width[7:0] = b;
                    found      = 1'b1;
                    begin_skip(seg_len >= FRAME_HDR_LEN ? seg_len - FRAME_HDR_LEN : 16'd0);
                end
                PH_SLEN_HI: begin
                    seg_len = {b, 8'h00};
                    phase   = PH_SLEN_LO;
                end
                PH_SLEN_LO: begin
                    seg_len[7:0] = b;
                    begin_skip(seg_len >= LEN_FIELD_LEN ? seg_len - LEN_FIELD_LEN : 16'd0);
                end
                PH_SKIP: begin
                    skip_left = skip_left - 16'd1;
                    if (skip_left == 0)
                        phase = PH_SYNC;
                end
                default: begin
                    if (b != SYNC_BYTE) begin
                        ends = 1'b1;
                        why  = CAUSE_SYNC;
                    end else begin
                        phase = PH_MARKER;
                    end
                end
            endcase

            if (!ends && last) begin
                ends = 1'b1;
                why  = CAUSE_EOD;
            end
            if (ends) begin
                r.found  = found;
                r.width  = found ? width : 16'd0;
                r.height = found ? height : 16'd0;
                r.cause  = why;
                expected_sizes.push_back(r);
                if (last)
                    rearm();
                else
                    finished = 1'b1;
            end
        endtask

        task check_result(logic f, logic [15:0] w, logic [15:0] h, logic [1:0] c);
            result_t e;
            if (expected_sizes.size() == 0) begin
                report($sformatf("unexpected result found=%0b w=%0d h=%0d cause=%0d",
                                 f, w, h, c));
                return;
            end
            e = expected_sizes.pop_front();
            if (f !== e.found)
                report($sformatf("found_frame %0b, want %0b", f, e.found));
            if (w !== e.width)
                report($sformatf("image_width %0d, want %0d", w, e.width));
            if (h !== e.height)
                report($sformatf("image_height %0d, want %0d", h, e.height));
            if (c !== e.cause)
                report($sformatf("end_cause %0d, want %0d", c, e.cause));
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic        s_last_byte;
    logic        m_valid;
    logic        m_ready;
    logic        m_found_frame;
    logic [15:0] m_image_width;
    logic [15:0] m_image_height;
    logic [1:0]  m_end_cause;

    frame_size_scoreboard sb;
    logic [7:0]           file_bytes[$];
    bit                   calm;
    bit                   sender_gaps;
    int                   quiet_cycles;

    jpeg_header_dimension_parser_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found_frame  (m_found_frame),
        .m_image_width  (m_image_width),
        .m_image_height (m_image_height),
        .m_end_cause    (m_end_cause)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // accepted words on both channels, sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready)
                sb.check_result(m_found_frame, m_image_width, m_image_height, m_end_cause);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TIMEOUT: no word moved for %0d cycles", STALL_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (!calm && $urandom_range(0, 9) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(0, 3))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void add(logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    function automatic void add_seg(logic [7:0] mk, int len);
        logic [15:0] l16;
        l16 = 16'(len);
        add(SYNC_BYTE);
        add(mk);
        add(l16[15:8]);
        add(l16[7:0]);
        for (int i = 0; i < len - 2; i++)
            add(rnd8());
    endfunction

    function automatic void add_frame(int len, logic [15:0] h, logic [15:0] w);
        logic [15:0] l16;
        l16 = 16'(len);
        add(SYNC_BYTE);
        add(MK_SOF0);
        add(l16[15:8]);
        add(l16[7:0]);
        add(rnd8());
        add(h[15:8]);
        add(h[7:0]);
        add(w[15:8]);
        add(w[7:0]);
        for (int i = 0; i < len - 7; i++)
            add(rnd8());
    endfunction

    function automatic void add_dri();
        add(SYNC_BYTE);
        add(MK_DRI);
        repeat (4) add(rnd8());
    endfunction

    task automatic send_byte(logic [7:0] b, logic last);
        // hold valid low for a burst now and then
        if (!calm && sender_gaps && $urandom_range(0, 7) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic send_file();
        int n;
        n = file_bytes.size();
        sender_gaps = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
    endtask

    function automatic void build_random_file();
        int         len;
        int         k;
        logic [7:0] mk;
        if ($urandom_range(0, 9) != 0) begin
            add(SYNC_BYTE);
            add(MK_SOI);
        end
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    mk = rnd8();
                    if (mk == MK_SOF0 || mk == MK_SOF2 || mk == MK_SOI ||
                        mk == MK_SOS || mk == MK_DRI)
                        mk = 8'hE1;
                    if ($urandom_range(0, 15) == 0)
                        mk = SYNC_BYTE;
                    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 300)
                                                        : $urandom_range(0, 24);
                    add_seg(mk, len);
                end
                2: add_dri();
                3, 4: begin
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6)
                                                       : $urandom_range(7, 20);
                    add_frame(len, pick_dim(), pick_dim());
                end
                default: begin
                    add(SYNC_BYTE);
                    add(MK_SOI);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                add(SYNC_BYTE);
                add(MK_SOS);
                repeat ($urandom_range(0, 4)) add(rnd8());
            end
            4: begin
                add(SYNC_BYTE);
                add(MK_SOF2);
                repeat ($urandom_range(0, 4)) add(rnd8());
            end
            5: begin
                mk = rnd8();
                if (mk == SYNC_BYTE)
                    mk = 8'h00;
                add(mk);
                repeat ($urandom_range(0, 4)) add(rnd8());
            end
            6: ;
            7: begin
                // cut the file short somewhere
                if (file_bytes.size() > 1) begin
                    k = $urandom_range(1, file_bytes.size());
                    while (file_bytes.size() > k)
                        void'(file_bytes.pop_back());
                end
            end
            8: begin
                if (file_bytes.size() > 0)
                    file_bytes[$urandom_range(0, file_bytes.size() - 1)] = rnd8();
            end
            default: begin
                add(SYNC_BYTE);
                add(rnd8());
            end
        endcase
        if (file_bytes.size() == 0)
            add(rnd8());
    endfunction

    initial begin
        int sent;
        sb           = new();
        calm         = 1'b0;
        sender_gaps  = 1'b0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = 8'h00;
        s_last_byte  = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // zero sizes, scan start on the file's last word
        add(SYNC_BYTE); add(MK_SOI);
        add_frame(17, 16'h0000, 16'h0000);
        add(SYNC_BYTE); add(MK_SOS);
        send_file();

        // all-ones sizes behind a restart interval, bytes after scan start ignored
        add(SYNC_BYTE); add(MK_SOI);
        add_dri();
        add_frame(7, 16'hFFFF, 16'hFFFF);
        add(SYNC_BYTE); add(MK_SOS);
        add(8'h12); add(8'hFF); add(8'hD9);
        send_file();

        // short frame and segment lengths, then progressive
        add_frame(3, 16'h1234, 16'h5678);
        add(SYNC_BYTE); add(8'hE0); add(8'h00); add(8'h01);
        add(SYNC_BYTE); add(8'hE0); add(8'h00); add(8'h00);
        add(SYNC_BYTE); add(MK_SOF2);
        add(8'h00);
        send_file();

        // frame cut short before the width low byte
        add(SYNC_BYTE); add(MK_SOI);
        add(SYNC_BYTE); add(MK_SOF0); add(8'h00); add(8'h0B);
        add(8'h08); add(8'h12); add(8'h34); add(8'h56);
        send_file();

        // lost sync, both as the last word and mid-file
        add(8'h00);
        send_file();
        add(8'h12); add(8'h34); add(8'hFF);
        send_file();

        // 0xFF as a marker, then end of data right after start of image
        add_seg(SYNC_BYTE, 4);
        add(SYNC_BYTE); add(MK_SOS);
        send_file();
        add(SYNC_BYTE); add(MK_SOI);
        send_file();

        // skip length with a set high byte
        add(SYNC_BYTE); add(MK_SOI);
        add_seg(8'hFE, 16'h0123);
        add_frame(8, pick_dim(), pick_dim());
        add(SYNC_BYTE); add(MK_SOS);
        send_file();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            build_random_file();
            sent += file_bytes.size();
            calm = (sent > RANDOM_BYTES - CALM_BYTES);
            send_file();
        end
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### jpeg_header_dimension_parser_unit.f
design/jhdp_pkg.sv
design/jhdp_parser.sv
design/jhdp_out_reg.sv
design/jpeg_header_dimension_parser_unit.sv
sim/jpeg_header_dimension_parser_unit_tb.sv
